// ===== rtl/core/hmsr_pkg.sv =====
package hmsr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SUN_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUN_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUN_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd4;

	localparam int SUN_W  = 16;
	localparam int SIZE_W = 9;
	localparam int HGT_W  = 8;
	localparam int PIX_W  = 8;

	// vertical position and step: 34-bit signed, saturating
	localparam int Z_W = 34;
	localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
	localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

	// divider: numerator is at most |sun_z|*255 (23 bits, held in 24) before the fraction shift,
	// denominator at most 200*32768 (23 bits)
	localparam int NUM_BASE_W = 24;
	localparam int DEN_W      = 23;
	localparam int REM_W      = DEN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INIT,
		ST_CHECK,
		ST_CMP
	} hmsr_state_t;

endpackage

// ===== rtl/core/hmsr_ram.sv =====
module hmsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/heightmap_shadow_ray_march.sv =====
// Heightmap shadow ray march.
// Configuration: cfg_we/cfg_index/cfg_wdata write sun_x, sun_y, sun_z, map_width and
// map_height (indices 0..4); write only while busy is low and no result
// is pending.
// Requests: a transaction is taken at a clock edge with start high and busy low.
// req_type 0 writes height into cell (row, col) of the map store; busy stays low
// and no result follows. req_type 1 queries the pixel (col, row).
// Results: done pulses for one cycle with shadowed; the receiver cannot hold it off.
// Query timing: a query outside the map, or with no horizontal sun component,
// answers in the next cycle with busy low. Otherwise busy stays high while three
// restoring divisions run on one shared subtractor, then the ray is set up, and each
// cell visited takes a cell address state, then a registered store read and compare.
// The march ends at the exit check, or at the compare (ray below the cell, or guard).
// At most MAX_SIDE-1 cells are visited, and done rises as busy falls.
// The store's single read port is registered, which splits each cell step into the
// address state and the compare state.
// Reset: registers return to sun = 0 and map size 256 x 256; the height store is not
// cleared and a cell must be written before a ray reaches it.
module heightmap_shadow_ray_march
	import hmsr_pkg::*;
#(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [PIX_W-1:0]      col,
	input  logic [PIX_W-1:0]      row,
	input  logic [HGT_W-1:0]      height,
	output logic                  done,
	output logic                  shadowed
);

	localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
	localparam int CIDX_W    = $clog2(MAX_SIDE);
	localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int POS_W     = SIDE_W + FRAC_BITS + 1;
	localparam int NUM_W     = NUM_BASE_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int GUARD_LAST = 2 * MAX_SIDE + 2;
	localparam int GUARD_W   = $clog2(GUARD_LAST + 1);

	// configuration registers
	logic signed [SUN_W-1:0] sun_x_q, sun_y_q, sun_z_q;
	logic [SIZE_W-1:0]       map_width_q, map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_x_q      <= '0;
			sun_y_q      <= '0;
			sun_z_q      <= '0;
			map_width_q  <= SIZE_W'(256);
			map_height_q <= SIZE_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SUN_X:      sun_x_q      <= cfg_wdata;
				REG_SUN_Y:      sun_y_q      <= cfg_wdata;
				REG_SUN_Z:      sun_z_q      <= cfg_wdata;
				REG_MAP_WIDTH:  map_width_q  <= cfg_wdata[SIZE_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// derived configuration
	logic [SIDE_W-1:0]     w_eff, h_eff;
	logic [SUN_W-1:0]      ax, ay, az, m;
	logic [NUM_BASE_W-1:0] az255;
	logic [DEN_W-1:0]      m200;

	always_comb begin
		if (map_width_q == '0)                    w_eff = SIDE_W'(1);
		else if (32'(map_width_q) > 32'(MAX_SIDE)) w_eff = SIDE_W'(MAX_SIDE);
		else                                      w_eff = SIDE_W'(map_width_q);
		if (map_height_q == '0)                    h_eff = SIDE_W'(1);
		else if (32'(map_height_q) > 32'(MAX_SIDE)) h_eff = SIDE_W'(MAX_SIDE);
		else                                       h_eff = SIDE_W'(map_height_q);
	end

	assign ax    = sun_x_q[SUN_W-1] ? SUN_W'(-sun_x_q) : SUN_W'(sun_x_q);
	assign ay    = sun_y_q[SUN_W-1] ? SUN_W'(-sun_y_q) : SUN_W'(sun_y_q);
	assign az    = sun_z_q[SUN_W-1] ? SUN_W'(-sun_z_q) : SUN_W'(sun_z_q);
	assign m     = (ax >= ay) ? ax : ay;
	assign az255 = (NUM_BASE_W'(az) << 8) - NUM_BASE_W'(az);
	assign m200  = (DEN_W'(m) << 7) + (DEN_W'(m) << 6) + (DEN_W'(m) << 3);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CIDX_W-1:0] r,
	                                               input logic [CIDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
	endfunction

	function automatic logic signed [Z_W-1:0] sat_z_add(input logic signed [Z_W-1:0] a,
	                                                   input logic signed [Z_W-1:0] b);
		logic signed [Z_W:0] s;
		s = {a[Z_W-1], a} + {b[Z_W-1], b};
		if (s[Z_W] != s[Z_W-1]) return s[Z_W] ? Z_MIN : Z_MAX;
		return s[Z_W-1:0];
	endfunction

	// state and datapath registers
	hmsr_state_t              state_q, state_d;
	logic [NUM_W-1:0]         num_q, num_d;
	logic [REM_W-1:0]         rem_q, rem_d;
	logic [DEN_W-1:0]         den_q, den_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [1:0]               sel_q, sel_d;
	logic [PIX_W-1:0]         col_q, col_d, row_q, row_d;
	logic signed [POS_W-1:0]  step_x_q, step_x_d, step_y_q, step_y_d;
	logic signed [Z_W-1:0]    step_z_q, step_z_d;
	logic signed [POS_W-1:0]  ray_x_q, ray_x_d, ray_y_q, ray_y_d;
	logic signed [Z_W-1:0]    ray_z_q, ray_z_d;
	logic [GUARD_W-1:0]       guard_q, guard_d;
	logic                     done_q, done_d, shad_q, shad_d;

	// store
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [HGT_W-1:0]  ram_rdata;

	assign ram_we    = start && !busy && !req_type
	                   && (32'(col) < 32'(MAX_SIDE)) && (32'(row) < 32'(MAX_SIDE));
	assign ram_waddr = cell_addr(CIDX_W'(row), CIDX_W'(col));

	hmsr_ram #(
		.WIDTH(HGT_W),
		.DEPTH(MAX_SIDE * MAX_SIDE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(height),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared divider step
	logic [REM_W-1:0]      rem_sh;
	logic                  div_ge;
	logic [NUM_W-1:0]      quot;
	logic [Z_W-1:0]        quot_sat;
	logic                  quot_neg;
	logic signed [Z_W-1:0] quot_s;

	assign rem_sh   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign div_ge   = rem_sh >= REM_W'(den_q);
	assign quot     = {num_q[NUM_W-2:0], div_ge};
	assign quot_sat = (64'(quot) > 64'(Z_MAX)) ? Z_MAX : Z_W'(quot);
	assign quot_neg = (sel_q == 2'd0) ? sun_x_q[SUN_W-1] :
	                  (sel_q == 2'd1) ? sun_y_q[SUN_W-1] : sun_z_q[SUN_W-1];
	assign quot_s   = quot_neg ? -$signed(quot_sat) : $signed(quot_sat);

	// march helpers
	logic [SIDE_W-1:0]     cx, cy;
	logic                  ray_out;
	logic signed [Z_W-1:0] h_start, h_cell;
	logic signed [POS_W-1:0] x_start, y_start;

	assign cx      = ray_x_q[POS_W-2:FRAC_BITS];
	assign cy      = ray_y_q[POS_W-2:FRAC_BITS];
	assign ray_out = ray_x_q[POS_W-1] || ray_y_q[POS_W-1] || (cx >= w_eff) || (cy >= h_eff);
	assign h_start = $signed(Z_W'(ram_rdata) << FRAC_BITS);
	assign h_cell  = h_start;
	assign x_start = $signed((POS_W'(col_q) << FRAC_BITS) | (POS_W'(1) << (FRAC_BITS - 1)));
	assign y_start = $signed((POS_W'(row_q) << FRAC_BITS) | (POS_W'(1) << (FRAC_BITS - 1)));

	always_comb begin
		state_d  = state_q;
		num_d    = num_q;
		rem_d    = rem_q;
		den_d    = den_q;
		cnt_d    = cnt_q;
		sel_d    = sel_q;
		col_d    = col_q;
		row_d    = row_q;
		step_x_d = step_x_q;
		step_y_d = step_y_q;
		step_z_d = step_z_q;
		ray_x_d  = ray_x_q;
		ray_y_d  = ray_y_q;
		ray_z_d  = ray_z_q;
		guard_d  = guard_q;
		done_d   = 1'b0;
		shad_d   = shad_q;
		ram_raddr = cell_addr(CIDX_W'(row_q), CIDX_W'(col_q));

		unique case (state_q)
			ST_IDLE: begin
				if (start && req_type) begin
					if ((32'(col) >= 32'(w_eff)) || (32'(row) >= 32'(h_eff)) || (m == '0)) begin
						done_d = 1'b1;
						shad_d = 1'b0;
					end else begin
						col_d   = col;
						row_d   = row;
						num_d   = NUM_W'(ax) << FRAC_BITS;
						den_d   = DEN_W'(m);
						rem_d   = '0;
						cnt_d   = '0;
						sel_d   = 2'd0;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				num_d = quot;
				rem_d = div_ge ? rem_sh - REM_W'(den_q) : rem_sh;
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					cnt_d = '0;
					rem_d = '0;
					if (sel_q == 2'd0) begin
						step_x_d = POS_W'(quot_s);
						num_d    = NUM_W'(ay) << FRAC_BITS;
						sel_d    = 2'd1;
					end else if (sel_q == 2'd1) begin
						step_y_d = POS_W'(quot_s);
						num_d    = NUM_W'(az255) << FRAC_BITS;
						den_d    = m200;
						sel_d    = 2'd2;
					end else begin
						step_z_d = quot_s;
						state_d  = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				// start at the pixel centre and its own height, then skip the pixel
				ray_x_d = x_start + step_x_q;
				ray_y_d = y_start + step_y_q;
				ray_z_d = sat_z_add(h_start, step_z_q);
				guard_d = '0;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (ray_out) begin
					done_d  = 1'b1;
					shad_d  = 1'b0;
					state_d = ST_IDLE;
				end else begin
					ram_raddr = cell_addr(CIDX_W'(cy), CIDX_W'(cx));
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				if (ray_z_q < h_cell) begin
					done_d  = 1'b1;
					shad_d  = 1'b1;
					state_d = ST_IDLE;
				end else if (guard_q == GUARD_W'(GUARD_LAST)) begin
					done_d  = 1'b1;
					shad_d  = 1'b0;
					state_d = ST_IDLE;
				end else begin
					ray_x_d = ray_x_q + step_x_q;
					ray_y_d = ray_y_q + step_y_q;
					ray_z_d = sat_z_add(ray_z_q, step_z_q);
					guard_d = guard_q + GUARD_W'(1);
					state_d = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			sel_q   <= 2'd0;
			guard_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			guard_q <= guard_d;
		end
	end

	always_ff @(posedge clk) begin
		num_q    <= num_d;
		rem_q    <= rem_d;
		den_q    <= den_d;
		col_q    <= col_d;
		row_q    <= row_d;
		step_x_q <= step_x_d;
		step_y_q <= step_y_d;
		step_z_q <= step_z_d;
		ray_x_q  <= ray_x_d;
		ray_y_q  <= ray_y_d;
		ray_z_q  <= ray_z_d;
		shad_q   <= shad_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign shadowed = shad_q;

endmodule

// ===== rtl/core/hmsr_chk.sv =====
module hmsr_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic done
);

	// a result only follows a query taken last cycle or the end of a march
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && req_type)))
		else $error("result without a query behind it");

	// a height write never occupies the block
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req_type) |=> !busy)
		else $error("height write made the block busy");

	// leaving the march always delivers its transaction
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("march ended without a result");

	// only an accepted query starts a march
	a_rise_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req_type))
		else $error("busy without an accepted query");

endmodule

bind heightmap_shadow_ray_march hmsr_chk u_hmsr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.req_type(req_type),
	.done    (done)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import hmsr_pkg::*;

	localparam int MAP_SIDE = 256;
	localparam int FRAC = 16;
	localparam longint CELL_UNIT = 64'sd1 << FRAC;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

	localparam int SETTLE_CYCLES = 4;
	localparam int END_HOLD = 700;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 9;

	typedef enum {SUN_ANY, SUN_SHALLOW, SUN_EXTREME, SUN_LOW_ELEV} sun_mode_t;

	typedef struct {
		logic [PIX_W-1:0] qcol;
		logic [PIX_W-1:0] qrow;
		bit               shade;
	} shadow_note_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [PIX_W-1:0]      col;
	logic [PIX_W-1:0]      row;
	logic [HGT_W-1:0]      height;
	logic                  done;
	logic                  shadowed;

	heightmap_shadow_ray_march DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.col      (col),
		.row      (row),
		.height   (height),
		.done     (done),
		.shadowed (shadowed)
	);

	// mirror of the block's terrain and registers
	logic [HGT_W-1:0]        terrain [MAP_SIDE*MAP_SIDE];
	logic signed [SUN_W-1:0] sun_dir_x;
	logic signed [SUN_W-1:0] sun_dir_y;
	logic signed [SUN_W-1:0] sun_dir_z;
	logic [SIZE_W-1:0]       map_cols;
	logic [SIZE_W-1:0]       map_rows;

	shadow_note_t shadow_expected [$];
	shadow_note_t oldest;
	int  error_count;
	int  quiet_cycles;
	bit  sender_gaps;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int cell_at(input longint r, input longint c);
		return int'(r) * MAP_SIDE + int'(c);
	endfunction

	function automatic longint side_in_use(input logic [SIZE_W-1:0] s);
		if (s == '0)
			return 1;
		if (s > MAP_SIDE)
			return MAP_SIDE;
		return longint'(s);
	endfunction

	function automatic longint clip_z(input longint v);
		if (v > longint'(Z_MAX))
			return longint'(Z_MAX);
		if (v < longint'(Z_MIN))
			return longint'(Z_MIN);
		return v;
	endfunction

	function automatic bit predict_shadow(input logic [PIX_W-1:0] qc, input logic [PIX_W-1:0] qr);
		longint cols, rows, ax, ay, span, dx, dy, dz, px, py, pz, cx, cy;
		cols = side_in_use(map_cols);
		rows = side_in_use(map_rows);
		ax = longint'(sun_dir_x);
		ay = longint'(sun_dir_y);
		if (ax < 0)
			ax = -ax;
		if (ay < 0)
			ay = -ay;
		span = (ax >= ay) ? ax : ay;
		if (qc >= cols || qr >= rows || span == 0)
			return 1'b0;
		// signed division truncates toward zero, as the block's quotient does
		dx = longint'(sun_dir_x) * CELL_UNIT / span;
		dy = longint'(sun_dir_y) * CELL_UNIT / span;
		dz = clip_z(longint'(sun_dir_z) * 255 * CELL_UNIT / (200 * span));
		px = longint'(qc) * CELL_UNIT + CELL_UNIT / 2 + dx;
		py = longint'(qr) * CELL_UNIT + CELL_UNIT / 2 + dy;
		pz = clip_z(longint'(terrain[cell_at(qr, qc)]) * CELL_UNIT + dz);
		for (int hop = 0; hop <= 2 * MAP_SIDE + 2; hop++) begin
			if (px < 0 || py < 0)
				return 1'b0;
			cx = px >>> FRAC;
			cy = py >>> FRAC;
			if (cx >= cols || cy >= rows)
				return 1'b0;
			if (pz < longint'(terrain[cell_at(cy, cx)]) * CELL_UNIT)
				return 1'b1;
			px += dx;
			py += dy;
			pz = clip_z(pz + dz);
		end
		return 1'b0;
	endfunction

	function automatic logic [SUN_W-1:0] pick_sun(input sun_mode_t mode);
		int extremes [5] = '{-32768, 32767, 0, 1, -1};
		case (mode)
			SUN_SHALLOW: return SUN_W'($urandom_range(0, 12) - 6);
			SUN_EXTREME: return SUN_W'(extremes[$urandom_range(0, 4)]);
			default:     return SUN_W'($urandom);
		endcase
	endfunction

	// returns at the edge that ends the last expected result plus a short settle
	task automatic await_results();
		start <= 1'b0;
		while (shadow_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		await_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SUN_X:      sun_dir_x = data;
			REG_SUN_Y:      sun_dir_y = data;
			REG_SUN_Z:      sun_dir_z = data;
			REG_MAP_WIDTH:  map_cols = data[SIZE_W-1:0];
			REG_MAP_HEIGHT: map_rows = data[SIZE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sun(input logic [SUN_W-1:0] sx, input logic [SUN_W-1:0] sy,
			input logic [SUN_W-1:0] sz);
		write_reg(REG_SUN_X, sx);
		write_reg(REG_SUN_Y, sy);
		write_reg(REG_SUN_Z, sz);
	endtask

	task automatic set_map(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv);
		write_reg(REG_MAP_WIDTH, wv);
		write_reg(REG_MAP_HEIGHT, hv);
	endtask

	task automatic aim_sun(input sun_mode_t mode);
		logic [SUN_W-1:0] zv;
		zv = pick_sun(mode);
		// low elevation: vertical component well below the horizontal ones
		if (mode == SUN_LOW_ELEV)
			zv = SUN_W'($signed(zv) >>> 6);
		set_sun(pick_sun(mode), pick_sun(mode), zv);
	endtask

	// drives one transaction and leaves start high for a back-to-back follower
	task automatic issue_request(input logic kind, input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] r, input logic [HGT_W-1:0] h);
		if (sender_gaps && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		col      <= c;
		row      <= r;
		height   <= h;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if (kind == REQ_WRITE)
			terrain[cell_at(r, c)] = h;
		else
			shadow_expected.push_back('{qcol: c, qrow: r, shade: predict_shadow(c, r)});
	endtask

	// every cell of the map gets written before any ray can reach it
	task automatic load_terrain(input int cols, input int rows);
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++)
				issue_request(REQ_WRITE, PIX_W'(c), PIX_W'(r), HGT_W'($urandom));
	endtask

	task automatic random_item(input int cols, input int rows);
		logic [PIX_W-1:0] c, r;
		bool_pick: begin end
		if ($urandom_range(0, 99) < 75) begin
			c = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(0, cols - 1));
			r = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(0, rows - 1));
			issue_request(REQ_QUERY, c, r, HGT_W'($urandom));
		end else begin
			if ($urandom_range(0, 1)) begin
				c = PIX_W'($urandom_range(0, cols - 1));
				r = PIX_W'($urandom_range(0, rows - 1));
			end else begin
				c = PIX_W'($urandom);
				r = PIX_W'($urandom);
			end
			issue_request(REQ_WRITE, c, r, HGT_W'($urandom));
		end
	endtask

	task automatic run_traffic(input int cols, input int rows, input int rounds, input int per_round);
		for (int rd = 0; rd < rounds; rd++) begin
			aim_sun(sun_mode_t'($urandom_range(0, 3)));
			for (int n = 0; n < per_round; n++)
				random_item(cols, rows);
		end
	endtask

	task automatic test_reset_state();
		// sun is zero after reset, so no cell is read
		issue_request(REQ_QUERY, 8'd0, 8'd0, 8'hFF);
		issue_request(REQ_QUERY, 8'd255, 8'd255, 8'h00);
		issue_request(REQ_WRITE, 8'd255, 8'd255, 8'hFF);
		issue_request(REQ_QUERY, 8'd0, 8'd255, 8'hA5);
		issue_request(REQ_QUERY, 8'd255, 8'd0, 8'h5A);
		await_results();
	endtask

	task automatic test_directed_terrain();
		logic [HGT_W-1:0] relief [12] = '{8'd10, 8'd50, 8'd20, 8'd255,
			8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0};
		sender_gaps = 1'b1;
		set_map(16'd4, 16'd3);
		for (int i = 0; i < 12; i++)
			issue_request(REQ_WRITE, PIX_W'(i % 4), PIX_W'(i / 4), relief[i]);
		// level sun along +x: taller neighbour, taller cell further on, clear edge, flat row
		set_sun(16'd1, 16'd0, 16'd0);
		issue_request(REQ_QUERY, 8'd0, 8'd0, 8'd0);
		issue_request(REQ_QUERY, 8'd1, 8'd0, 8'd0);
		issue_request(REQ_QUERY, 8'd3, 8'd0, 8'd0);
		issue_request(REQ_QUERY, 8'd0, 8'd1, 8'd0);
		// pixel outside the map in each axis
		issue_request(REQ_QUERY, 8'd4, 8'd0, 8'd0);
		issue_request(REQ_QUERY, 8'd0, 8'd3, 8'd0);
		// straight overhead: no horizontal component
		set_sun(16'd0, 16'd0, 16'h7FFF);
		issue_request(REQ_QUERY, 8'd1, 8'd1, 8'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		issue_request(REQ_QUERY, 8'd1, 8'd1, 8'd0);
		set_sun(16'h8000, 16'h0000, 16'h7FFF);
		issue_request(REQ_QUERY, 8'd3, 8'd2, 8'd0);
		set_sun(16'h8000, 16'h8000, 16'h8000);
		issue_request(REQ_QUERY, 8'd3, 8'd2, 8'd0);
		issue_request(REQ_QUERY, 8'd2, 8'd2, 8'd0);
		set_sun(16'h7FFF, 16'hFFFF, 16'h0000);
		issue_request(REQ_QUERY, 8'd0, 8'd2, 8'd0);
	endtask

	task automatic test_strip_maps();
		sender_gaps = 1'b0;
		// 9-bit register: 0x1FF acts as the full side, 0 as one row
		set_map(16'hFFFF, 16'hFE00);
		load_terrain(MAP_SIDE, 1);
		run_traffic(MAP_SIDE, 1, 4, 10);
		set_map(16'd256, 16'd1);
		run_traffic(MAP_SIDE, 1, 2, 10);
		set_map(16'd0, 16'd256);
		load_terrain(1, MAP_SIDE);
		run_traffic(1, MAP_SIDE, 4, 10);
		set_map(16'd1, 16'h01FF);
		run_traffic(1, MAP_SIDE, 1, 10);
	endtask

	task automatic test_random_terrain();
		int cols, rows, tmp;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// first phase runs without sender gaps
			sender_gaps = (phase != 0);
			cols = $urandom_range(1, 32);
			rows = $urandom_range(1, 128 / cols);
			if ($urandom_range(0, 1)) begin
				tmp  = cols;
				cols = rows;
				rows = tmp;
			end
			set_map(CFG_DATA_W'(cols) | (CFG_DATA_W'($urandom_range(0, 127)) << SIZE_W),
				CFG_DATA_W'(rows) | (CFG_DATA_W'($urandom_range(0, 127)) << SIZE_W));
			load_terrain(cols, rows);
			run_traffic(cols, rows, 3, 30);
		end
	endtask

	// result check, sampled mid-cycle
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (shadow_expected.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result transaction: shadowed=%0b", shadowed);
			end else begin
				oldest = shadow_expected.pop_front();
				if (shadowed !== oldest.shade) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("shadowed mismatch at col %0d row %0d: expected %0b, got %0b",
							oldest.qcol, oldest.qrow, oldest.shade, shadowed);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_SUN_X;
		cfg_wdata <= '0;
		start     <= 1'b0;
		req_type  <= REQ_WRITE;
		col       <= '0;
		row       <= '0;
		height    <= '0;
		sun_dir_x = '0;
		sun_dir_y = '0;
		sun_dir_z = '0;
		map_cols  = SIZE_W'(MAP_SIDE);
		map_rows  = SIZE_W'(MAP_SIDE);
		error_count  = 0;
		quiet_cycles = 0;
		sender_gaps  = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_terrain();
		test_strip_maps();
		test_random_terrain();

		await_results();
		repeat (END_HOLD) @(posedge clk);
		error_count += shadow_expected.size();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
